// File: src/kpsm_pkg.sv
// Package for the keypad scanner with multi-tap entry.
// Holds the phase enum, event codes, state, config and result structs and the key tables.
// No dependencies.
package kpsm_pkg;

    localparam int KP_ROWS = 4;
    localparam int KP_COLS = 3;
    localparam int ROW_W   = $clog2(KP_ROWS);
    localparam int COL_W   = 2;
    localparam int TAP_W   = 3;
    localparam int CHAR_W  = 7;
    localparam int TICK_W  = 16;

    localparam logic [COL_W-1:0]  COL_NONE  = 2'd3;
    localparam logic [CHAR_W-1:0] CHAR_HASH = 7'h23;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_MODE     = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HELD    = 2'd2,
        PH_RELEASE = 2'd3
    } kpsm_phase_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_UPDATE  = 2'd1,
        EV_CHANGE  = 2'd2,
        EV_TIMEOUT = 2'd3
    } kpsm_event_t;

    typedef struct packed {
        logic [ROW_W-1:0]  scan_row;
        logic              scan_enabled;
        kpsm_phase_t       phase;
        logic [COL_W-1:0]  pending_column;
        logic [ROW_W-1:0]  held_row;
        logic [COL_W-1:0]  held_col;
        logic [TAP_W-1:0]  tap_count;
        logic              tapping;
        logic [TICK_W-1:0] tick_count;
    } kpsm_state_t;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] timeout_ticks;
        logic              multitap_mode;
    } kpsm_cfg_t;

    typedef struct packed {
        logic [TAP_W-1:0]   tap_index;
        logic [COL_W-1:0]   key_col;
        logic [ROW_W-1:0]   key_row;
        logic [CHAR_W-1:0]  char_code;
        kpsm_event_t        event_res;
        logic [KP_ROWS-1:0] row_drive;
    } kpsm_result_t;

    // Character of a key at a position in its letter cycle; 0 where nothing is defined.
    function automatic logic [CHAR_W-1:0] key_char(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [TAP_W-1:0] tap);
        logic [4:0][CHAR_W-1:0] chars;
        chars = '0;
        unique case ({row, col})
            {2'd0, 2'd0}: chars = {7'h00, 7'h00, 7'h00, 7'h00, 7'h31};
            {2'd0, 2'd1}: chars = {7'h00, 7'h43, 7'h42, 7'h41, 7'h32};
            {2'd0, 2'd2}: chars = {7'h00, 7'h46, 7'h45, 7'h44, 7'h33};
            {2'd1, 2'd0}: chars = {7'h00, 7'h49, 7'h48, 7'h47, 7'h34};
            {2'd1, 2'd1}: chars = {7'h00, 7'h4C, 7'h4B, 7'h4A, 7'h35};
            {2'd1, 2'd2}: chars = {7'h00, 7'h4F, 7'h4E, 7'h4D, 7'h36};
            {2'd2, 2'd0}: chars = {7'h53, 7'h52, 7'h51, 7'h50, 7'h37};
            {2'd2, 2'd1}: chars = {7'h00, 7'h56, 7'h55, 7'h54, 7'h38};
            {2'd2, 2'd2}: chars = {7'h5A, 7'h59, 7'h58, 7'h57, 7'h39};
            {2'd3, 2'd0}: chars = {7'h00, 7'h00, 7'h00, 7'h00, 7'h2A};
            {2'd3, 2'd1}: chars = {7'h00, 7'h00, 7'h00, 7'h20, 7'h30};
            {2'd3, 2'd2}: chars = {7'h00, 7'h00, 7'h00, 7'h00, CHAR_HASH};
            default:      chars = '0;
        endcase
        if (tap > 3'd4) begin
            return '0;
        end
        return chars[tap];
    endfunction

    // Number of characters in a key's cycle.
    function automatic logic [TAP_W-1:0] cycle_len(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        logic [TAP_W-1:0] len;
        len = 3'd1;
        unique case ({row, col})
            {2'd0, 2'd1}, {2'd0, 2'd2},
            {2'd1, 2'd0}, {2'd1, 2'd1}, {2'd1, 2'd2},
            {2'd2, 2'd1}: len = 3'd4;
            {2'd2, 2'd0}, {2'd2, 2'd2}: len = 3'd5;
            {2'd3, 2'd1}: len = 3'd2;
            default:      len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

// File: src/kpsm_step.sv
// Next-state and result logic for one scan tick of the keypad scanner.
// Depends on kpsm_pkg for the state, config and result types and the key tables.
module kpsm_step (
    input  kpsm_pkg::kpsm_state_t        state_cur,
    input  kpsm_pkg::kpsm_cfg_t          cfg,
    input  logic [kpsm_pkg::KP_COLS-1:0] column_sense,
    output kpsm_pkg::kpsm_state_t        state_next,
    output kpsm_pkg::kpsm_result_t       result
);
    import kpsm_pkg::*;

    logic [COL_W-1:0] col;
    logic             deb_done;
    logic             tmo_done;
    logic             same_key;
    logic [TAP_W-1:0] tap_inc;
    logic [TAP_W-1:0] tap_adv;
    logic             restart;
    kpsm_phase_t      phase_next;
    kpsm_event_t      event_next;
    kpsm_state_t      nxt;

    // Lowest set column wins.
    always_comb begin
        priority if (column_sense[0]) col = 2'd0;
        else if (column_sense[1])     col = 2'd1;
        else if (column_sense[2])     col = 2'd2;
        else                          col = COL_NONE;
    end

    assign deb_done = (state_cur.tick_count >= cfg.debounce_ticks);
    assign tmo_done = (state_cur.tick_count >= cfg.timeout_ticks);
    assign same_key = (state_cur.held_row == state_cur.scan_row) && (state_cur.held_col == col);
    assign tap_inc  = state_cur.tap_count + 3'd1;
    assign tap_adv  = (tap_inc >= cycle_len(state_cur.held_row, state_cur.held_col)) ?
                      '0 : tap_inc;

    // Phase transitions.
    always_comb begin
        phase_next = state_cur.phase;
        unique case (state_cur.phase)
            PH_IDLE: begin
                if (col != COL_NONE) phase_next = PH_PRESS;
            end
            PH_PRESS: begin
                if (deb_done) begin
                    phase_next = (col != state_cur.pending_column) ? PH_IDLE : PH_HELD;
                end
            end
            PH_HELD: begin
                if (col == COL_NONE) phase_next = PH_RELEASE;
            end
            PH_RELEASE: begin
                if (deb_done) begin
                    phase_next = (col != COL_NONE) ? PH_HELD : PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Datapath registers and event code.
    always_comb begin
        nxt        = state_cur;
        event_next = EV_NONE;
        restart    = 1'b0;
        unique case (state_cur.phase)
            PH_IDLE: begin
                // A press takes precedence over the tap timeout.
                priority if (col != COL_NONE) begin
                    nxt.scan_enabled   = 1'b0;
                    nxt.pending_column = col;
                    restart            = 1'b1;
                end else if (state_cur.tapping && tmo_done) begin
                    nxt.tapping = 1'b0;
                    event_next  = EV_TIMEOUT;
                end
            end
            PH_PRESS: begin
                if (deb_done) begin
                    priority if (col != state_cur.pending_column) begin
                        nxt.pending_column = COL_NONE;
                        nxt.scan_enabled   = 1'b1;
                    end else if (cfg.multitap_mode) begin
                        priority if (state_cur.tapping && same_key) begin
                            nxt.tap_count = tap_adv;
                            event_next    = EV_UPDATE;
                        end else begin
                            nxt.held_row  = state_cur.scan_row;
                            nxt.held_col  = col;
                            nxt.tap_count = '0;
                            event_next    = state_cur.tapping ? EV_CHANGE : EV_UPDATE;
                        end
                    end else begin
                        nxt.held_row  = state_cur.scan_row;
                        nxt.held_col  = col;
                        nxt.tap_count = '0;
                        if (key_char(state_cur.scan_row, col, '0) == CHAR_HASH) begin
                            nxt.tapping = 1'b0;
                        end
                        event_next = EV_UPDATE;
                    end
                end
            end
            PH_HELD: begin
                if (col == COL_NONE) restart = 1'b1;
            end
            PH_RELEASE: begin
                if (deb_done && (col == COL_NONE)) begin
                    if (cfg.multitap_mode) begin
                        nxt.tapping = (key_char(state_cur.held_row, state_cur.held_col,
                                                state_cur.tap_count) != CHAR_HASH);
                        restart     = 1'b1;
                    end
                    nxt.scan_enabled = 1'b1;
                end
            end
            default: begin
                nxt = state_cur;
            end
        endcase

        nxt.phase = phase_next;
        if (nxt.scan_enabled) begin
            nxt.scan_row = state_cur.scan_row + 2'd1;
        end
        priority if (restart) begin
            nxt.tick_count = '0;
        end else if (state_cur.tick_count != {TICK_W{1'b1}}) begin
            nxt.tick_count = state_cur.tick_count + 16'd1;
        end
    end

    assign state_next = nxt;

    always_comb begin
        result.row_drive = KP_ROWS'(1) << nxt.scan_row;
        result.event_res = event_next;
        result.char_code = key_char(nxt.held_row, nxt.held_col, nxt.tap_count);
        result.key_row   = nxt.held_row;
        result.key_col   = nxt.held_col;
        result.tap_index = nxt.tap_count;
    end

endmodule

// File: src/keypad_scan_multitap_top.sv
// Top level of the 4x3 matrix keypad scanner with multi-tap letter entry.
// Depends on kpsm_pkg and kpsm_step.
//
// Each input item is one timer tick carrying the three column sense lines; each
// accepted item produces exactly one result item in the next cycle, holding the row
// to drive next, the event of that tick and the current key and character. The
// block takes one item per clock: the scanner state updates on acceptance and the
// result sits in a single output register, so input is taken whenever that register
// is empty or being read in the same cycle. Configuration writes go to the three
// registers by index (0 debounce ticks, 1 multi-tap timeout ticks, 2 mode) and must
// only be issued while no result is outstanding.
module keypad_scan_multitap_top (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [2:0] column_sense, [7:3] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: [3:0] row_drive, [5:4] event_res, [12:6] char_code, [14:13] key_row,
    //          [16:15] key_col, [19:17] tap_index, [23:20] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import kpsm_pkg::*;

    kpsm_state_t  state_reg;
    kpsm_state_t  state_next;
    kpsm_cfg_t    cfg_reg;
    kpsm_result_t result_next;
    kpsm_result_t result_reg;
    logic         m_valid_reg;
    logic         in_accept;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    kpsm_step u_step (
        .state_cur    (state_reg),
        .cfg          (cfg_reg),
        .column_sense (s_tdata[KP_COLS-1:0]),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= 16'd20;
            cfg_reg.timeout_ticks  <= 16'd1000;
            cfg_reg.multitap_mode  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_wdata;
                CFG_TIMEOUT:  cfg_reg.timeout_ticks  <= cfg_wdata;
                CFG_MODE:     cfg_reg.multitap_mode  <= cfg_wdata[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.scan_row       <= '0;
            state_reg.scan_enabled   <= 1'b1;
            state_reg.phase          <= PH_IDLE;
            state_reg.pending_column <= COL_NONE;
            state_reg.held_row       <= 2'd3;
            state_reg.held_col       <= 2'd2;
            state_reg.tap_count      <= '0;
            state_reg.tapping        <= 1'b0;
            state_reg.tick_count     <= '0;
        end else if (in_accept) begin
            state_reg <= state_next;
        end else if (cfg_wr_en && (cfg_addr == CFG_MODE)) begin
            // A mode write ends tapping if no item is accepted; mode 0 resets the letter.
            state_reg.tapping <= 1'b0;
            if (!cfg_wdata[0]) begin
                state_reg.tap_count <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, result_reg};

    // The driven row is always one-hot on a valid result.
    a_row_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[3:0]))
        else $error("row_drive not one-hot");

    // An accepted item always leaves a result behind.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid)
        else $error("accepted item produced no result");

    // The held key never names the unused column.
    a_key_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:15] != COL_NONE))
        else $error("key_col out of range");

    // While a key is held the scan is frozen.
    a_scan_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (state_reg.phase == PH_HELD)) |=> $stable(state_reg.scan_row))
        else $error("scan advanced while key held");

endmodule
